### hw/rtl/negh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// negh_pkg
// shared constants, codes and types of the event gate histogram
// ----------------------------------------------------------------------------
package negh_pkg;

	// default sizes
	localparam int TUBE_COUNT_DEF  = 51;
	localparam int TUBE_PIXELS_DEF = 64;
	localparam int PIXEL_GROUP_DEF = 16;
	localparam int COUNT_BITS_DEF  = 32;

	// field widths
	localparam int CMD_W    = 3;
	localparam int TUBE_W   = 8;
	localparam int PIXEL_W  = 12;
	localparam int TIME_W   = 32;
	localparam int INDEX_W  = 13;
	localparam int VALUE_W  = 6;
	localparam int STATUS_W = 3;
	localparam int REG_W    = 32;
	localparam int REG_IDX_W = 3;
	localparam int PHYS_W   = 7;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 112;

	// commands
	localparam logic [CMD_W-1:0] CMD_EVENT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FRAME = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MAP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MASK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

	// result status
	localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WINDOW  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_GATES   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MASKED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd5;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_GATE_PERIOD  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIRECT_LOW   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIRECT_HIGH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ANALYSED_LOW = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ANALYSED_HIGH = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_FRAME  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LAST_FRAME   = 3'd6;

	// register reset values
	localparam logic [REG_W-1:0] GATE_PERIOD_RST = 32'd23570000;
	localparam logic [REG_W-1:0] ALL_ONES_RST    = 32'hFFFF_FFFF;

	// store access strobes
	typedef struct packed {
		logic rd_en;
		logic cnt_we;
		logic mask_we;
		logic mask_bit;
	} store_ctl_t;

endpackage

### hw/rtl/negh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// negh_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module negh_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          ge;

	// divisor zero: every step subtracts nothing, remainder ends as the dividend
	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? W'(trial - {1'b0, div_q}) : W'(trial);
			quo_q <= W'({quo_q, ge});
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### hw/rtl/negh_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// negh_store
// bin count and keep mask memories with clearing pass after reset
// ----------------------------------------------------------------------------
module negh_store #(
	parameter int NUM_BINS   = 6528,
	parameter int AW         = 13,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  negh_pkg::store_ctl_t  ctl,
	input  logic [AW-1:0]         addr,
	input  logic [COUNT_BITS-1:0] cnt_wdata,
	output logic [COUNT_BITS-1:0] rd_count,
	output logic                  rd_keep,
	output logic                  clearing
);
	logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
	logic                  mask_mem [NUM_BINS];

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(NUM_BINS - 1))
				clr_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			cnt_mem[clr_addr_q] <= '0;
		end else if (ctl.cnt_we) begin
			cnt_mem[addr] <= cnt_wdata;
		end
		if (ctl.rd_en)
			rd_count <= cnt_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mask_mem[clr_addr_q] <= 1'b1;
		end else if (ctl.mask_we) begin
			mask_mem[addr] <= ctl.mask_bit;
		end
		if (ctl.rd_en)
			rd_keep <= mask_mem[addr];
	end

	assign clearing = clr_q;

endmodule

### hw/rtl/neutron_event_gate_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neutron_event_gate_histogram
// frame-window and chopper-gate filter with a per-bin event histogram
// ----------------------------------------------------------------------------
// usage
//  - one command item enters on s_axis, one result item leaves on m_axis
//  - commands: event, new frame, tube map write, mask bit write, count read
//  - config registers are written through cfg_we/cfg_addr/cfg_data; write them only while idle (not enforced)
//  - an event inside the frame window runs a bit-serial fold of aux_time by
//    gate_period (one quotient bit a cycle) alongside the pixel grouping
//    divide, then gate check, bin build, count read and write back: the
//    result is then registered in the output register, and the next item
//    can be taken once the sequencer is back in idle
//  - events outside the frame window, map and mask writes, unused commands
//    and out-of-range count reads go straight to the output state, a new
//    frame via the frame state, a count read via the update state; an
//    in-window event failing the range or gate check still waits for the fold
//  - one item is worked on at a time; the next is taken once the result has
//    gone into the output register, so a waiting result does not block it
//  - after reset the count and mask memories are swept, one bin a cycle,
//    over all NUM_BINS bins (6528 by default); s_axis_tready stays low meanwhile
//  - when the receiver stalls, the finished result holds in the output
//    register and the block holds the next result until the slot frees
// ----------------------------------------------------------------------------
module neutron_event_gate_histogram #(
	parameter int TUBE_COUNT  = negh_pkg::TUBE_COUNT_DEF,
	parameter int TUBE_PIXELS = negh_pkg::TUBE_PIXELS_DEF,
	parameter int PIXEL_GROUP = negh_pkg::PIXEL_GROUP_DEF,
	parameter int COUNT_BITS  = negh_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command, tube, pixel, aux_time, table_index, table_value
	input  logic [negh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// status, bin_index, bin_count, frames_seen, frames_valid
	output logic [negh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_we,
	input  logic [negh_pkg::REG_IDX_W-1:0]      cfg_addr,
	input  logic [negh_pkg::REG_W-1:0]          cfg_data
);
	localparam int NUM_BINS = 2 * TUBE_COUNT * TUBE_PIXELS;
	localparam int AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int TMW = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
	localparam int BW  = $clog2(TUBE_PIXELS) + negh_pkg::PHYS_W;

	// sequencer states
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_GATE  = 4'd3;
	localparam logic [3:0] S_BIN   = 4'd4;
	localparam logic [3:0] S_READ  = 4'd5;
	localparam logic [3:0] S_UPD   = 4'd6;
	localparam logic [3:0] S_FRAME = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	// input field unpacking
	logic [negh_pkg::CMD_W-1:0]   in_cmd;
	logic [negh_pkg::TUBE_W-1:0]  in_tube;
	logic [negh_pkg::PIXEL_W-1:0] in_pixel;
	logic [negh_pkg::TIME_W-1:0]  in_time;
	logic [negh_pkg::INDEX_W-1:0] in_idx;
	logic [negh_pkg::VALUE_W-1:0] in_val;

	assign in_cmd   = s_axis_tdata[2:0];
	assign in_tube  = s_axis_tdata[10:3];
	assign in_pixel = s_axis_tdata[22:11];
	assign in_time  = s_axis_tdata[54:23];
	assign in_idx   = s_axis_tdata[67:55];
	assign in_val   = s_axis_tdata[73:68];

	// config registers
	logic [31:0] gate_period_q, dir_low_q, dir_high_q, ana_low_q, ana_high_q;
	logic [31:0] first_frame_q, last_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_period_q <= negh_pkg::GATE_PERIOD_RST;
			dir_low_q     <= '0;
			dir_high_q    <= '0;
			ana_low_q     <= '0;
			ana_high_q    <= negh_pkg::ALL_ONES_RST;
			first_frame_q <= '0;
			last_frame_q  <= negh_pkg::ALL_ONES_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				negh_pkg::REG_GATE_PERIOD:   gate_period_q <= cfg_data;
				negh_pkg::REG_DIRECT_LOW:    dir_low_q     <= cfg_data;
				negh_pkg::REG_DIRECT_HIGH:   dir_high_q    <= cfg_data;
				negh_pkg::REG_ANALYSED_LOW:  ana_low_q     <= cfg_data;
				negh_pkg::REG_ANALYSED_HIGH: ana_high_q    <= cfg_data;
				negh_pkg::REG_FIRST_FRAME:   first_frame_q <= cfg_data;
				negh_pkg::REG_LAST_FRAME:    last_frame_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// control and working registers
	logic [3:0]  state_q;
	logic [31:0] frame_q, valid_q;
	logic [negh_pkg::TUBE_W-1:0]   tube_q;
	logic [negh_pkg::PHYS_W-1:0]   phys_q;
	logic [BW-1:0]                 bin_q;
	logic                          rd_only_q;
	logic [negh_pkg::STATUS_W-1:0] res_status_q;
	logic [negh_pkg::INDEX_W-1:0]  res_bin_q;
	logic [31:0]                   res_count_q;
	logic                          out_valid_q;
	logic [negh_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [negh_pkg::VALUE_W-1:0]  tube_map_q [TUBE_COUNT];

	logic accept;
	logic in_win;
	logic clearing;

	assign s_axis_tready = (state_q == S_IDLE) && !clearing;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_win        = (frame_q >= first_frame_q) && (frame_q <= last_frame_q);

	// serial units: time fold and pixel grouping run side by side
	logic                         div_start;
	logic                         fold_done, grp_done;
	logic [31:0]                  fold_quo, fold_rem;
	logic [negh_pkg::PIXEL_W-1:0] grp_quo, grp_rem;

	assign div_start = accept && (in_cmd == negh_pkg::CMD_EVENT) && in_win;

	negh_div #(.W(negh_pkg::TIME_W)) u_fold (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(in_time), .divisor(gate_period_q),
		.done(fold_done), .quotient(fold_quo), .remainder(fold_rem)
	);

	negh_div #(.W(negh_pkg::PIXEL_W)) u_group (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(in_pixel), .divisor(negh_pkg::PIXEL_W'(PIXEL_GROUP)),
		.done(grp_done), .quotient(grp_quo), .remainder(grp_rem)
	);

	// gate windows on the folded time
	logic in_direct, in_analysed, pos_ok;
	assign in_direct   = (fold_rem >= dir_low_q) && (fold_rem <= dir_high_q);
	assign in_analysed = (fold_rem >= ana_low_q) && (fold_rem <= ana_high_q);
	assign pos_ok      = (32'(tube_q) < 32'(TUBE_COUNT)) && (32'(grp_quo) < 32'(TUBE_PIXELS));

	// store access
	negh_pkg::store_ctl_t  st_ctl;
	logic [AW-1:0]         st_addr;
	logic [COUNT_BITS-1:0] rd_count, cnt_inc;
	logic                  rd_keep;
	logic                  idx_in_bins;

	assign idx_in_bins = 32'(in_idx) < 32'(NUM_BINS);
	assign cnt_inc = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count : rd_count + 1'b1;

	always_comb begin
		st_ctl   = '0;
		st_addr  = AW'(bin_q);
		if (state_q == S_IDLE) begin
			st_addr         = AW'(in_idx);
			st_ctl.rd_en    = accept && (in_cmd == negh_pkg::CMD_READ) && idx_in_bins;
			st_ctl.mask_we  = accept && (in_cmd == negh_pkg::CMD_MASK) && idx_in_bins;
			st_ctl.mask_bit = in_val[0];
		end else if (state_q == S_READ) begin
			st_ctl.rd_en = 32'(bin_q) < 32'(NUM_BINS);
		end else if (state_q == S_UPD) begin
			st_ctl.cnt_we = !rd_only_q && rd_keep;
		end
	end

	negh_store #(.NUM_BINS(NUM_BINS), .AW(AW), .COUNT_BITS(COUNT_BITS)) u_store (
		.clk(clk), .arst_n(arst_n), .ctl(st_ctl), .addr(st_addr),
		.cnt_wdata(cnt_inc), .rd_count(rd_count), .rd_keep(rd_keep),
		.clearing(clearing)
	);

	// tube map, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TUBE_COUNT; i++)
				tube_map_q[i] <= '0;
		end else if (accept && (in_cmd == negh_pkg::CMD_MAP) &&
				(32'(in_idx) < 32'(TUBE_COUNT))) begin
			tube_map_q[TMW'(in_idx)] <= in_val;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			frame_q     <= '0;
			valid_q     <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (!clearing)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (in_cmd)
							negh_pkg::CMD_EVENT: state_q <= in_win ? S_DIV : S_OUT;
							negh_pkg::CMD_FRAME: begin
								if (frame_q != 32'hFFFF_FFFF)
									frame_q <= frame_q + 1'b1;
								state_q <= S_FRAME;
							end
							negh_pkg::CMD_READ: state_q <= idx_in_bins ? S_UPD : S_OUT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_DIV: begin
					if (fold_done)
						state_q <= S_GATE;
				end
				S_GATE: begin
					state_q <= (pos_ok && (in_direct || in_analysed)) ? S_BIN : S_OUT;
				end
				S_BIN: state_q <= S_READ;
				S_READ: state_q <= (32'(bin_q) < 32'(NUM_BINS)) ? S_UPD : S_OUT;
				S_UPD: state_q <= S_OUT;
				S_FRAME: begin
					if (in_win && (valid_q != 32'hFFFF_FFFF))
						valid_q <= valid_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register: loaded from the output state, emptied once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((state_q == S_OUT) && (!out_valid_q || m_axis_tready))
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tube_q       <= in_tube;
				rd_only_q    <= in_cmd == negh_pkg::CMD_READ;
				res_count_q  <= '0;
				if (in_cmd == negh_pkg::CMD_EVENT) begin
					res_status_q <= negh_pkg::ST_WINDOW;
					res_bin_q    <= '0;
				end else if (in_cmd == negh_pkg::CMD_READ) begin
					res_status_q <= negh_pkg::ST_DONE;
					res_bin_q    <= in_idx;
				end else begin
					res_status_q <= negh_pkg::ST_DONE;
					res_bin_q    <= '0;
				end
			end
			S_GATE: begin
				// direct wins where both windows hold
				phys_q <= in_direct ?
					negh_pkg::PHYS_W'(tube_map_q[TMW'(tube_q)]) + negh_pkg::PHYS_W'(TUBE_COUNT) :
					negh_pkg::PHYS_W'(tube_map_q[TMW'(tube_q)]);
				res_status_q <= pos_ok ? negh_pkg::ST_GATES : negh_pkg::ST_RANGE;
			end
			S_BIN: begin
				bin_q <= BW'(32'(TUBE_PIXELS) * 32'(phys_q)) + BW'(grp_quo);
				res_status_q <= negh_pkg::ST_RANGE;
			end
			S_UPD: begin
				if (rd_only_q) begin
					res_count_q <= 32'(rd_count);
				end else if (!rd_keep) begin
					res_status_q <= negh_pkg::ST_MASKED;
					res_bin_q    <= negh_pkg::INDEX_W'(bin_q);
					res_count_q  <= 32'(rd_count);
				end else begin
					res_status_q <= negh_pkg::ST_COUNTED;
					res_bin_q    <= negh_pkg::INDEX_W'(bin_q);
					res_count_q  <= 32'(cnt_inc);
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_axis_tready)
					out_data_q <= {valid_q, frame_q, res_count_q, res_bin_q, res_status_q};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// frame counter only moves up
	a_frame_mono: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q >= $past(frame_q)) else $error("frame counter went back");

	// the serial units finish only while the sequencer waits for them
	a_fold_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(fold_done || grp_done) |-> state_q == S_DIV) else $error("fold done outside wait");

	// an in-window event starts the serial units
	a_event_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd == negh_pkg::CMD_EVENT && in_win) |=> state_q == S_DIV)
		else $error("event did not start fold");

	// a new result appears only after the output state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output state");

	// no memory writes during the clearing sweep from the sequencer
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !st_ctl.cnt_we && !st_ctl.mask_we)
		else $error("store written during clear");

endmodule
